@@ hw/rtl/sxh_pkg.sv @@
// Shared constants, register indexes and unit request/response types for the hash block.
package sxh_pkg;

  localparam int SEG_LEN = 32;
  localparam int POS_W   = $clog2(SEG_LEN + 1);
  localparam int BYTE_W  = 8;
  localparam int HASH_W  = 64;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 3;
  localparam int IDX_W   = ADDR_W - 2;
  localparam int CNT_W   = $clog2(HASH_W);

  localparam logic [IDX_W-1:0] REG_BASE_MULT = 1'b0;
  localparam logic [IDX_W-1:0] REG_MODULUS   = 1'b1;

  localparam logic [CFG_W-1:0] BASE_MULT_RST = 32'd31;
  localparam logic [CFG_W-1:0] MODULUS_RST   = 32'd4294967291;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [CFG_W-1:0]  modulus;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ hw/rtl/sxh_if.sv @@
// Valid/ready channel interfaces for input bytes and hash results.
interface sxh_in_if;
  logic                      valid;
  logic                      ready;
  logic [sxh_pkg::BYTE_W-1:0] data_byte;
  logic                      is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface sxh_out_if;
  logic                      valid;
  logic                      ready;
  logic [sxh_pkg::HASH_W-1:0] hash_sum;

  modport source (output valid, output hash_sum, input ready);
  modport sink   (input valid, input hash_sum, output ready);
endinterface

@@ hw/rtl/sxh_div.sv @@
// Bit-serial remainder unit: 64-bit dividend modulo a 32-bit divisor, one bit per cycle.
module sxh_div (
  input  logic              clk,
  input  logic              rst,
  input  sxh_pkg::div_req_t req,
  output sxh_pkg::div_rsp_t rsp
);

  logic                         busy;
  logic [sxh_pkg::CNT_W-1:0]    cnt;
  logic [sxh_pkg::HASH_W-1:0]   dividend;
  logic [sxh_pkg::CFG_W-1:0]    divisor;
  logic [sxh_pkg::CFG_W-1:0]    rem;
  logic [sxh_pkg::CFG_W:0]      shifted;
  logic [sxh_pkg::CFG_W:0]      diff;
  logic [sxh_pkg::CFG_W-1:0]    rem_next;
  logic                         done;

  assign shifted = {rem, dividend[sxh_pkg::HASH_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    if (shifted >= {1'b0, divisor}) begin
      rem_next = diff[sxh_pkg::CFG_W-1:0];
    end else begin
      rem_next = shifted[sxh_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy     <= 1'b1;
        cnt      <= '0;
        dividend <= req.dividend;
        divisor  <= req.modulus;
        rem      <= '0;
      end else if (busy) begin
        rem      <= rem_next;
        dividend <= {dividend[sxh_pkg::HASH_W-2:0], 1'b0};
        cnt      <= cnt + 1'b1;
        if (cnt == sxh_pkg::CNT_W'(sxh_pkg::HASH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

@@ hw/rtl/sxh_core.sv @@
// Byte sequencer: shared 32x32 multiplier, segment and total bookkeeping, result register.
module sxh_core (
  input  logic                      clk,
  input  logic                      rst,
  sxh_in_if.sink                    in_ch,
  sxh_out_if.source                 out_ch,
  input  logic [sxh_pkg::CFG_W-1:0] base_mult,
  input  logic [sxh_pkg::CFG_W-1:0] modulus,
  output sxh_pkg::div_req_t         div_req,
  input  sxh_pkg::div_rsp_t         div_rsp
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_LO = 3'd1;
  localparam logic [2:0] ST_MUL_HI = 3'd2;
  localparam logic [2:0] ST_ADD    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_POST   = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]                   state;
  logic [sxh_pkg::HASH_W-1:0]   seg;
  logic [sxh_pkg::HASH_W-1:0]   total;
  logic [sxh_pkg::POS_W-1:0]    pos;
  logic [sxh_pkg::POS_W-1:0]    pos_inc;
  logic [sxh_pkg::BYTE_W-1:0]   cur_byte;
  logic                         last;
  logic [sxh_pkg::HASH_W-1:0]   acc;
  logic [sxh_pkg::HASH_W-1:0]   preg;
  logic [sxh_pkg::CFG_W-1:0]    mul_a;
  logic [sxh_pkg::HASH_W-1:0]   prod;
  logic [sxh_pkg::HASH_W-1:0]   cur_ext;
  logic [sxh_pkg::HASH_W-1:0]   in_ext;
  logic                         out_valid;
  logic [sxh_pkg::HASH_W-1:0]   out_hash;

  assign in_ext  = {{(sxh_pkg::HASH_W - sxh_pkg::BYTE_W){in_ch.data_byte[sxh_pkg::BYTE_W-1]}},
                    in_ch.data_byte};
  assign cur_ext = {{(sxh_pkg::HASH_W - sxh_pkg::BYTE_W){cur_byte[sxh_pkg::BYTE_W-1]}},
                    cur_byte};

  assign mul_a   = (state == ST_MUL_LO) ? acc[sxh_pkg::CFG_W-1:0]
                                        : acc[sxh_pkg::HASH_W-1:sxh_pkg::CFG_W];
  assign prod    = {{sxh_pkg::CFG_W{1'b0}}, mul_a} * {{sxh_pkg::CFG_W{1'b0}}, base_mult};
  assign pos_inc = pos + 1'b1;

  assign in_ch.ready     = (state == ST_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.hash_sum = out_hash;

  assign div_req.start    = (state == ST_ADD) && (modulus != '0);
  assign div_req.dividend = acc + {preg[sxh_pkg::CFG_W-1:0], {sxh_pkg::CFG_W{1'b0}}};
  assign div_req.modulus  = modulus;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg       <= '0;
      total     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            acc      <= seg ^ in_ext;
            cur_byte <= in_ch.data_byte;
            last     <= in_ch.is_last;
            state    <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          preg  <= prod;
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          acc   <= preg + cur_ext;
          preg  <= prod;
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (modulus == '0) begin
            seg   <= div_req.dividend;
            state <= ST_POST;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            seg   <= {{(sxh_pkg::HASH_W - sxh_pkg::CFG_W){1'b0}}, div_rsp.remainder};
            state <= ST_POST;
          end
        end
        ST_POST: begin
          if (pos_inc >= sxh_pkg::POS_W'(sxh_pkg::SEG_LEN)) begin
            total <= total + seg;
            seg   <= '0;
            pos   <= '0;
            state <= last ? ST_EMIT : ST_IDLE;
          end else if (last) begin
            // pad the open segment with zero bytes
            pos      <= pos_inc;
            acc      <= seg;
            cur_byte <= '0;
            state    <= ST_MUL_LO;
          end else begin
            pos   <= pos_inc;
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_hash  <= total;
            out_valid <= 1'b1;
            total     <= '0;
            seg       <= '0;
            pos       <= '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/segmented_xor_mod_sum_hash.sv @@
// Top level of the segmented XOR/multiply/modulo hash with its register port.
// Takes one string byte per beat and returns one 64-bit sum per string, after the
// last byte has been processed. The input is not ready while a byte is processed: three
// steps on the shared 32x32 multiplier and adder, then the bit-serial remainder unit,
// which sets the rate; with a zero modulus the remainder unit is skipped. On the last
// byte the open segment is padded with zero bytes, each a further round, then the sum
// goes to the result register, which holds it while the next string is already being
// taken in. Registers: base multiplier at 0x0, modulus at 0x4; write only while no
// string is in progress.
module segmented_xor_mod_sum_hash (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sxh_pkg::ADDR_W-1:0] paddr,
  input  logic [sxh_pkg::CFG_W-1:0]  pwdata,
  output logic [sxh_pkg::CFG_W-1:0]  prdata,
  output logic                       pready,
  sxh_in_if.sink                     in_ch,
  sxh_out_if.source                  out_ch
);

  logic [sxh_pkg::CFG_W-1:0] base_mult;
  logic [sxh_pkg::CFG_W-1:0] modulus;
  logic [sxh_pkg::IDX_W-1:0] reg_idx;
  sxh_pkg::div_req_t         div_req;
  sxh_pkg::div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[sxh_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mult <= sxh_pkg::BASE_MULT_RST;
      modulus   <= sxh_pkg::MODULUS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        sxh_pkg::REG_BASE_MULT: base_mult <= pwdata;
        sxh_pkg::REG_MODULUS:   modulus   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sxh_pkg::REG_BASE_MULT: prdata = base_mult;
      sxh_pkg::REG_MODULUS:   prdata = modulus;
      default:                prdata = '0;
    endcase
  end

  sxh_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .base_mult (base_mult),
    .modulus   (modulus),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  sxh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready stayed high after an accepted beat");

  a_no_result_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !$rose(out_ch.valid))
    else $error("result appeared straight after an input beat");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised while the sequencer was idle");

endmodule
